/* design/hsed_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsed_pkg
// Shared types, codes and constant tables for the Hamming SEC encoder/decoder.
// ----------------------------------------------------------------------------
package hsed_pkg;

    localparam int WORD_W            = 64;
    localparam int CNT_W             = 6;
    localparam int SYND_W            = 6;
    localparam int DATA_LIMIT        = 57;
    localparam int MAX_DATA_BITS_DEF = 57;
    localparam logic [CNT_W-1:0] DATA_BITS_RESET = 6'd16;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FIXED  = 2'd1;
    localparam logic [1:0] ST_UNCORR = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [WORD_W-1:0] payload;
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0] result_word;
        logic [1:0]        status;
        logic [SYND_W-1:0] syndrome;
    } t_rsp;

    typedef struct packed {
        logic              valid;
        logic              op;
        logic [WORD_W-1:0] payload;
        logic [CNT_W-1:0]  n;
        logic [CNT_W-1:0]  len;
    } t_s0;

    typedef struct packed {
        logic              valid;
        logic              op;
        logic [WORD_W-1:0] word;
        logic [SYND_W-1:0] synd;
        logic [CNT_W-1:0]  n;
        logic [CNT_W-1:0]  len;
    } t_s1;

    typedef struct packed {
        logic              valid;
        logic              op;
        logic [WORD_W-1:0] word;
        logic [1:0]        status;
        logic [SYND_W-1:0] synd;
        logic [CNT_W-1:0]  n;
    } t_s2;

    typedef logic [DATA_LIMIT-1:0][SYND_W-1:0] t_pos_tab;
    typedef logic [SYND_W-1:0][WORD_W-1:0]     t_mask_tab;

    // codeword position of each data bit (non-power-of-two 1-based indices)
    function automatic t_pos_tab f_data_pos();
        t_pos_tab tab;
        int       d;
        int       q;
        tab = '0;
        d   = 0;
        for (int p = 0; p < WORD_W - 1; p++) begin
            q = p + 1;
            if (((q & (q - 1)) != 0) && (d < DATA_LIMIT)) begin
                tab[d] = SYND_W'(p);
                d++;
            end
        end
        return tab;
    endfunction

    // positions covered by each syndrome bit
    function automatic t_mask_tab f_par_masks();
        t_mask_tab m;
        m = '0;
        for (int k = 0; k < SYND_W; k++) begin
            for (int p = 0; p < WORD_W; p++) begin
                m[k][p] = (((p + 1) >> k) & 1) == 1;
            end
        end
        return m;
    endfunction

    // codeword length n + r, r smallest with 2^r >= n + r + 1
    function automatic logic [CNT_W-1:0] f_code_len(input logic [CNT_W-1:0] n);
        int r;
        r = SYND_W;
        for (int i = SYND_W; i >= 1; i--) begin
            if ((1 << i) >= int'(n) + i + 1) begin
                r = i;
            end
        end
        return CNT_W'(int'(n) + r);
    endfunction

    localparam t_pos_tab  DATA_POS = f_data_pos();
    localparam t_mask_tab PAR_MASK = f_par_masks();

endpackage

/* design/hsed_syndrome.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsed_syndrome
// Stage 1: build the working codeword (scatter on encode, trim on decode)
// and compute its syndrome.
// ----------------------------------------------------------------------------
module hsed_syndrome
    import hsed_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_s0  i_s0,
    output t_s1  o_s1
);

    t_s1               r_s1;
    t_s1               n_s1;
    logic [WORD_W-1:0] enc_word;
    logic [WORD_W-1:0] len_mask;

    always_comb begin
        enc_word = '0;
        for (int j = 0; j < DATA_LIMIT; j++) begin
            enc_word[DATA_POS[j]] = i_s0.payload[j] & (CNT_W'(j) < i_s0.n);
        end
        len_mask = ~({WORD_W{1'b1}} << i_s0.len);

        n_s1.valid = i_s0.valid;
        n_s1.op    = i_s0.op;
        n_s1.n     = i_s0.n;
        n_s1.len   = i_s0.len;
        n_s1.word  = (i_s0.op == OP_ENCODE) ? enc_word : (i_s0.payload & len_mask);
        for (int k = 0; k < SYND_W; k++) begin
            n_s1.synd[k] = ^(n_s1.word & PAR_MASK[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

/* design/hsed_correct.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsed_correct
// Stage 2: insert parity bits on encode; classify and fix a single error
// on decode.
// ----------------------------------------------------------------------------
module hsed_correct
    import hsed_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_s1  i_s1,
    output t_s2  o_s2
);

    t_s2 r_s2;
    t_s2 n_s2;

    always_comb begin
        n_s2.valid  = i_s1.valid;
        n_s2.op     = i_s1.op;
        n_s2.n      = i_s1.n;
        n_s2.word   = i_s1.word;
        n_s2.status = ST_OK;
        n_s2.synd   = '0;
        if (i_s1.op == OP_ENCODE) begin
            for (int k = 0; k < SYND_W; k++) begin
                n_s2.word[(1 << k) - 1] = i_s1.word[(1 << k) - 1] | i_s1.synd[k];
            end
        end else begin
            n_s2.synd = i_s1.synd;
            if (i_s1.synd != '0) begin
                if (i_s1.synd <= i_s1.len) begin
                    n_s2.word   = i_s1.word ^
                                  (WORD_W'(1) << SYND_W'(i_s1.synd - SYND_W'(1)));
                    n_s2.status = ST_FIXED;
                end else begin
                    n_s2.status = ST_UNCORR;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

/* design/hsed_gather.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsed_gather
// Stage 3: collect data bits on decode and register the result beat.
// ----------------------------------------------------------------------------
module hsed_gather
    import hsed_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_s2  i_s2,
    output logic o_valid,
    output t_rsp o_rsp
);

    logic              r_valid;
    t_rsp              r_rsp;
    t_rsp              n_rsp;
    logic [WORD_W-1:0] dec_data;

    always_comb begin
        dec_data = '0;
        for (int j = 0; j < DATA_LIMIT; j++) begin
            dec_data[j] = i_s2.word[DATA_POS[j]] & (CNT_W'(j) < i_s2.n);
        end
        n_rsp.result_word = (i_s2.op == OP_DECODE) ? dec_data : i_s2.word;
        n_rsp.status      = i_s2.status;
        n_rsp.syndrome    = i_s2.synd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_s2.valid;
            r_rsp   <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

/* design/hamming_sec_encode_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_sec_encode_decode
// Configurable-length Hamming single-error-correcting encoder/decoder.
// ----------------------------------------------------------------------------
// A command beat is taken on any cycle with start high; busy stays low, so one
// beat per cycle is sustained. Each result appears on o_rsp with o_valid high
// for one cycle, after the input register and three pipeline stages
// (syndrome, correct, gather). Results come out in command order and cannot
// be held off by the receiver. The data-bit count is to be written through
// i_cfg_we/i_cfg_data only while no beats are in flight; this is not enforced.
module hamming_sec_encode_decode
    import hsed_pkg::*;
#(
    parameter int MAX_DATA_BITS = MAX_DATA_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_cmd             i_cmd,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    output logic             o_valid,
    output t_rsp             o_rsp
);

    localparam logic [CNT_W-1:0] EFF_MAX =
        CNT_W'((MAX_DATA_BITS < DATA_LIMIT) ? MAX_DATA_BITS : DATA_LIMIT);

    logic [CNT_W-1:0] r_cfg;
    logic [CNT_W-1:0] n_eff;
    t_s0              r_s0;
    t_s0              n_s0;
    t_s1              s1;
    t_s2              s2;

    assign busy = 1'b0;

    always_comb begin
        n_eff = r_cfg;
        if (r_cfg == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_cfg > EFF_MAX) begin
            n_eff = EFF_MAX;
        end
        n_s0.valid   = start & ~busy;
        n_s0.op      = i_cmd.opcode;
        n_s0.payload = i_cmd.payload;
        n_s0.n       = n_eff;
        n_s0.len     = f_code_len(n_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= DATA_BITS_RESET;
            r_s0.valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_s0 <= n_s0;
        end
    end

    hsed_syndrome u_syndrome (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s0    (r_s0),
        .o_s1    (s1)
    );

    hsed_correct u_correct (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    hsed_gather u_gather (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s2    (s2),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

/* design/hsed_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsed_checker
// Port-level checks on latency and result coding, bound to the top level.
// ----------------------------------------------------------------------------
module hsed_checker
    import hsed_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input t_cmd             i_cmd,
    input logic             o_valid,
    input t_rsp             o_rsp
);

    // every accepted beat yields a result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("result missing after accepted beat");

    // no result without an accepted command
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##4 !o_valid)
        else $error("result without a command");

    // status reports an error exactly when the syndrome is nonzero
    a_status_synd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_rsp.status == ST_OK) == (o_rsp.syndrome == '0))
                    && (o_rsp.status != 2'd3))
        else $error("status and syndrome disagree");

    // encode results carry no error report
    a_encode_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_cmd.opcode, 4) == OP_ENCODE)) |->
            (o_rsp.status == ST_OK))
        else $error("encode beat reported an error");

endmodule

bind hamming_sec_encode_decode hsed_checker u_hsed_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_cmd      (i_cmd),
    .o_valid    (o_valid),
    .o_rsp      (o_rsp)
);

/* bench/hamming_sec_encode_decode_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_sec_encode_decode_tb
// Self-checking bench for the configurable-length Hamming SEC encoder/decoder.
// ----------------------------------------------------------------------------
// A short table of directed commands runs first. It covers the width extremes,
// stray payload bits, single-bit correction and out-of-range syndromes. Where a
// row's answer is obvious it is typed into the table. Random phases follow at
// a range of data widths. Most decode beats are encoded words with zero, one
// or two flipped bits. Every result is checked, field by field and in order,
// against its typed answer or an in-bench model of the code. Outside two
// steady phases, commands arrive in bursts with random gaps between them.
// ----------------------------------------------------------------------------
module hamming_sec_encode_decode_tb;
    import hsed_pkg::*;

    localparam int DATA_MAX     = MAX_DATA_BITS_DEF;
    localparam int ITEMS_PER_PH = 150;
    localparam int NUM_PHASES   = 11;
    localparam int DRAIN_CYC    = 8;

    typedef struct packed {
        logic [CNT_W-1:0] width;
        t_cmd             cmd;
        logic             typed;
        t_rsp             want;
    } t_dir_row;

    localparam int DIR_ROWS = 24;
    localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] D57  = 64'h01FF_FFFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0] C63  = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{6'd16, '{OP_ENCODE, 64'h0},                   1'b1, '{64'h0, ST_OK, 6'd0}},
        '{6'd16, '{OP_DECODE, 64'h0},                   1'b1, '{64'h0, ST_OK, 6'd0}},
        '{6'd16, '{OP_ENCODE, ONES},                    1'b0, '{64'h0, ST_OK, 6'd0}},
        '{6'd16, '{OP_ENCODE, 64'hFFFF_FFFF_FFFF_0000}, 1'b1, '{64'h0, ST_OK, 6'd0}},
        '{6'd16, '{OP_DECODE, 64'h1},                   1'b1, '{64'h0, ST_FIXED, 6'd1}},
        '{6'd16, '{OP_DECODE, 64'h0010_0000},           1'b1, '{64'h0, ST_FIXED, 6'd21}},
        '{6'd16, '{OP_DECODE, 64'h8080},                1'b1, '{64'h0, ST_UNCORR, 6'd24}},
        '{6'd16, '{OP_DECODE, 64'hFFFF_FFFF_FFE0_0000}, 1'b1, '{64'h0, ST_OK, 6'd0}},
        '{6'd16, '{OP_DECODE, 64'h0000_0000_0012_3456}, 1'b0, '{64'h0, ST_OK, 6'd0}},
        '{6'd0,  '{OP_ENCODE, 64'h1},                   1'b1, '{64'h7, ST_OK, 6'd0}},
        '{6'd0,  '{OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFE}, 1'b1, '{64'h0, ST_OK, 6'd0}},
        '{6'd0,  '{OP_DECODE, 64'h7},                   1'b1, '{64'h1, ST_OK, 6'd0}},
        '{6'd0,  '{OP_DECODE, 64'h4},                   1'b0, '{64'h0, ST_OK, 6'd0}},
        '{6'd5,  '{OP_DECODE, 64'h82},                  1'b1, '{64'h0, ST_UNCORR, 6'd10}},
        '{6'd5,  '{OP_ENCODE, 64'h1F},                  1'b0, '{64'h0, ST_OK, 6'd0}},
        '{6'd57, '{OP_ENCODE, 64'h0},                   1'b1, '{64'h0, ST_OK, 6'd0}},
        '{6'd57, '{OP_ENCODE, ONES},                    1'b1, '{C63, ST_OK, 6'd0}},
        '{6'd57, '{OP_DECODE, ONES},                    1'b1, '{D57, ST_OK, 6'd0}},
        '{6'd57, '{OP_DECODE, 64'hBFFF_FFFF_FFFF_FFFF}, 1'b1, '{D57, ST_FIXED, 6'd63}},
        '{6'd57, '{OP_DECODE, 64'h8000_0000_0000_0000}, 1'b1, '{64'h0, ST_OK, 6'd0}},
        '{6'd63, '{OP_ENCODE, ONES},                    1'b1, '{C63, ST_OK, 6'd0}},
        '{6'd63, '{OP_DECODE, 64'h1},                   1'b1, '{64'h0, ST_FIXED, 6'd1}},
        '{6'd58, '{OP_ENCODE, 64'h0123_4567_89AB_CDEF}, 1'b0, '{64'h0, ST_OK, 6'd0}},
        '{6'd4,  '{OP_DECODE, 64'h55},                  1'b0, '{64'h0, ST_OK, 6'd0}}
    };

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             busy;
    t_cmd             i_cmd      = '0;
    logic             i_cfg_we   = 1'b0;
    logic [CNT_W-1:0] i_cfg_data = '0;
    logic             o_valid;
    t_rsp             o_rsp;

    logic             beat_typed = 1'b0;
    t_rsp             beat_want  = '0;

    logic [CNT_W-1:0] width_reg  = DATA_BITS_RESET;
    t_rsp             due_rsp_q [$];
    int               mismatches = 0;
    int               n_enc      = 0;
    int               n_dec      = 0;
    int               n_fixed    = 0;
    int               n_uncorr   = 0;
    int               n_widths   = 0;

    hamming_sec_encode_decode #(
        .MAX_DATA_BITS (DATA_MAX)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    function automatic int width_eff(input logic [CNT_W-1:0] width);
        int n;
        n = int'(width);
        if (n < 1) n = 1;
        if (n > DATA_MAX) n = DATA_MAX;
        if (n > DATA_LIMIT) n = DATA_LIMIT;
        return n;
    endfunction

    function automatic int code_length(input int n);
        int r;
        r = 1;
        while (r < 7 && (1 << r) < n + r + 1) r++;
        return n + r;
    endfunction

    function automatic t_rsp hamming_code_rsp(input t_cmd c, input logic [CNT_W-1:0] width);
        int                n;
        int                len;
        int                d;
        int                s;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] data;
        t_rsp              rsp;
        n    = width_eff(width);
        len  = code_length(n);
        d    = 0;
        s    = 0;
        word = '0;
        data = '0;
        rsp  = '0;
        if (c.opcode == OP_ENCODE) begin
            for (int p = 0; p < len; p++) begin
                if (((p + 1) & p) != 0) begin
                    word[p] = c.payload[d];
                    d++;
                end
            end
            for (int p = 0; p < len; p++) begin
                if (word[p]) s = s ^ (p + 1);
            end
            for (int k = 0; k < len - n; k++) begin
                if (s[k]) word[(1 << k) - 1] = 1'b1;
            end
            rsp.result_word = word;
            rsp.status      = ST_OK;
            rsp.syndrome    = '0;
        end else begin
            word = c.payload;
            for (int p = 0; p < len; p++) begin
                if (word[p]) s = s ^ (p + 1);
            end
            rsp.status = ST_OK;
            if (s != 0) begin
                if (s <= len) begin
                    word[s - 1] = ~word[s - 1];
                    rsp.status  = ST_FIXED;
                end else begin
                    rsp.status = ST_UNCORR;
                end
            end
            for (int p = 0; p < len; p++) begin
                if (((p + 1) & p) != 0) begin
                    data[d] = word[p];
                    d++;
                end
            end
            rsp.result_word = data;
            rsp.syndrome    = SYND_W'(s);
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            width_reg = DATA_BITS_RESET;
        end else begin
            if (i_cfg_we) begin
                width_reg = i_cfg_data;
            end
            if (start && !busy) begin
                due_rsp_q.push_back(beat_typed ? beat_want : hamming_code_rsp(i_cmd, width_reg));
                if (i_cmd.opcode == OP_ENCODE) n_enc++;
                else n_dec++;
            end
            if (o_valid) begin
                if (due_rsp_q.size() == 0) begin
                    $error("unexpected result beat: word %h status %0d syndrome %0d",
                           o_rsp.result_word, o_rsp.status, o_rsp.syndrome);
                    mismatches++;
                end else begin
                    want = due_rsp_q.pop_front();
                    if (o_rsp.result_word !== want.result_word) begin
                        $error("result_word: expected %h, actual %h",
                               want.result_word, o_rsp.result_word);
                        mismatches++;
                    end
                    if (o_rsp.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_rsp.status);
                        mismatches++;
                    end
                    if (o_rsp.syndrome !== want.syndrome) begin
                        $error("syndrome: expected %0d, actual %0d",
                               want.syndrome, o_rsp.syndrome);
                        mismatches++;
                    end
                    if (want.status == ST_FIXED) n_fixed++;
                    if (want.status == ST_UNCORR) n_uncorr++;
                end
            end
        end
    end

    task automatic drive_beat(input t_cmd c, input logic typed, input t_rsp want);
        start      <= 1'b1;
        i_cmd      <= c;
        beat_typed <= typed;
        beat_want  <= want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_width(input logic [CNT_W-1:0] v);
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (due_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        n_widths++;
    endtask

    initial begin
        logic [CNT_W-1:0]  cur_w;
        logic [CNT_W-1:0]  ph_w [NUM_PHASES];
        t_cmd              c;
        t_rsp              none;
        int                kind;
        int                len;
        int                fa;
        int                fb;
        int                burst_left;
        int                gap;
        logic              steady;
        logic [WORD_W-1:0] stray;

        none       = '0;
        burst_left = 0;
        cur_w      = DATA_BITS_RESET;
        ph_w       = '{6'd1, 6'd57, 6'd0, 6'd63, 6'd16, 6'd11, 6'd26, 6'd4,
                       6'd0, 6'd0, 6'd0};
        for (int i = NUM_PHASES - 3; i < NUM_PHASES; i++) begin
            ph_w[i] = CNT_W'($urandom_range(0, 63));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TAB[i].width != cur_w) begin
                set_width(DIR_TAB[i].width);
                cur_w = DIR_TAB[i].width;
            end
            drive_beat(DIR_TAB[i].cmd, DIR_TAB[i].typed, DIR_TAB[i].want);
            if ($urandom_range(0, 2) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_width(ph_w[ph]);
            len    = code_length(width_eff(ph_w[ph]));
            steady = (ph == 2 || ph == 6);
            for (int i = 0; i < ITEMS_PER_PH; i++) begin
                kind = $urandom_range(0, 99);
                c.payload = {$urandom(), $urandom()};
                if (kind < 30) begin
                    c.opcode = OP_ENCODE;
                end else if (kind < 80) begin
                    c.opcode = OP_ENCODE;
                    c.payload = hamming_code_rsp(c, ph_w[ph]).result_word;
                    c.opcode = OP_DECODE;
                    fa = $urandom_range(0, len - 1);
                    fb = (fa + $urandom_range(1, len - 1)) % len;
                    case ($urandom_range(0, 3))
                        1, 2: begin
                            c.payload[fa] = ~c.payload[fa];
                        end
                        3: begin
                            c.payload[fa] = ~c.payload[fa];
                            c.payload[fb] = ~c.payload[fb];
                        end
                        default: ;
                    endcase
                    if ($urandom_range(0, 3) == 0) begin
                        stray = {$urandom(), $urandom()};
                        c.payload = c.payload | (stray & ~((64'd1 << len) - 64'd1));
                    end
                end else begin
                    c.opcode = OP_DECODE;
                end
                drive_beat(c, 1'b0, none);
                if (!steady) begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                          : $urandom_range(1, 6);
                        start <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end

        start <= 1'b0;
        for (int w = 0; w < 1000 && due_rsp_q.size() != 0; w++) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (due_rsp_q.size() != 0) begin
            $error("%0d expected results never arrived", due_rsp_q.size());
            mismatches++;
        end

        $display("Checked %0d encode and %0d decode beats over %0d width settings",
                 n_enc, n_dec, n_widths);
        $display("Decodes covered %0d single-bit corrections and %0d out-of-range syndromes",
                 n_fixed, n_uncorr);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
